// ----- hw/rtl/lfdc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line follower drive control package
// Shared widths, action and register codes, result types and pulse helpers.
// ----------------------------------------------------------------------------
package lfdc_pkg;

	localparam int SAMPLE_BITS = 10;

	localparam int THR_W      = 10;
	localparam int ECHO_W     = 15;
	localparam int BOOST_W    = 4;
	localparam int PULSE_W    = 11;
	localparam int HOLD_W     = 11;
	localparam int ACT_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// chosen_action codes
	localparam logic [ACT_W-1:0] ACT_FWD     = 3'd0;
	localparam logic [ACT_W-1:0] ACT_CURVE_R = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CURVE_L = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SPIN_R  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_SPIN_L  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_AVOID   = 3'd5;
	localparam logic [ACT_W-1:0] ACT_STOP    = 3'd6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LINE_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ECHO_LIMIT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOOST_AFTER    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_NORMAL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_BOOST    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_INNER    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_REVERSE  = 3'd6;

	// register reset values
	localparam logic [THR_W-1:0]   RST_LINE_THRESHOLD = 10'd800;
	localparam logic [ECHO_W-1:0]  RST_ECHO_LIMIT     = 15'd174;
	localparam logic [BOOST_W-1:0] RST_BOOST_AFTER    = 4'd8;
	localparam logic [PULSE_W-1:0] RST_PULSE_NORMAL   = 11'd1080;
	localparam logic [PULSE_W-1:0] RST_PULSE_BOOST    = 11'd1000;
	localparam logic [PULSE_W-1:0] RST_PULSE_INNER    = 11'd1350;
	localparam logic [PULSE_W-1:0] RST_PULSE_REVERSE  = 11'd1700;

	localparam logic [PULSE_W-1:0] PULSE_MIN   = 11'd1000;
	localparam logic [PULSE_W-1:0] PULSE_MAX   = 11'd2000;
	localparam logic [PULSE_W-1:0] PULSE_MID   = 11'd1500;
	localparam logic [PULSE_W:0]   MIRROR_BASE = 12'd3000;

	localparam logic [HOLD_W-1:0] HOLD_LINE    = 11'd10;
	localparam logic [HOLD_W-1:0] HOLD_AVOID   = 11'd1200;
	localparam logic [HOLD_W-1:0] HOLD_RESUME  = 11'd1000;
	localparam logic [HOLD_W-1:0] HOLD_FOREVER = 11'd0;

	typedef struct packed {
		logic [THR_W-1:0]   line_threshold;
		logic [ECHO_W-1:0]  obstacle_echo_limit;
		logic [BOOST_W-1:0] boost_after;
		logic [PULSE_W-1:0] pulse_normal;
		logic [PULSE_W-1:0] pulse_boost;
		logic [PULSE_W-1:0] pulse_inner;
		logic [PULSE_W-1:0] pulse_reverse;
	} cfg_t;

	typedef struct packed {
		logic [PULSE_W-1:0] drive_right;
		logic [PULSE_W-1:0] drive_left;
		logic [HOLD_W-1:0]  hold_time;
		logic [ACT_W-1:0]   chosen_action;
		logic               halted_flag;
		logic               last_of_run;
	} res_t;

	// one queue entry holds every result of one request
	typedef struct packed {
		res_t res0;
		res_t res1;
		logic two;
	} entry_t;

	function automatic logic [PULSE_W-1:0] clamp_pulse(input logic [PULSE_W:0] p);
		logic [PULSE_W-1:0] r;
		if (p < {1'b0, PULSE_MIN}) begin
			r = PULSE_MIN;
		end else if (p > {1'b0, PULSE_MAX}) begin
			r = PULSE_MAX;
		end else begin
			r = p[PULSE_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [PULSE_W-1:0] mirror(input logic [PULSE_W-1:0] p);
		logic [PULSE_W:0] d;
		d = MIRROR_BASE - {1'b0, p};
		return clamp_pulse(d);
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/lfdc_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor request channel
// Valid/ready channel carrying three reflectance samples and an echo time.
// ----------------------------------------------------------------------------
interface lfdc_in_if #(
	parameter int SAMPLE_BITS = lfdc_pkg::SAMPLE_BITS
);
	logic                         valid;
	logic                         ready;
	logic [SAMPLE_BITS-1:0]       sample_right;
	logic [SAMPLE_BITS-1:0]       sample_center;
	logic [SAMPLE_BITS-1:0]       sample_left;
	logic [lfdc_pkg::ECHO_W-1:0]  echo_time;

	modport source (output valid, sample_right, sample_center, sample_left, echo_time,
		input ready);
	modport sink (input valid, sample_right, sample_center, sample_left, echo_time,
		output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lfdc_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drive result channel
// Valid/ready channel carrying servo pulses, hold time and action flags.
// ----------------------------------------------------------------------------
interface lfdc_out_if;
	logic                          valid;
	logic                          ready;
	logic [lfdc_pkg::PULSE_W-1:0]  drive_right;
	logic [lfdc_pkg::PULSE_W-1:0]  drive_left;
	logic [lfdc_pkg::HOLD_W-1:0]   hold_time;
	logic [lfdc_pkg::ACT_W-1:0]    chosen_action;
	logic                          halted_flag;
	logic                          last_of_run;

	modport source (output valid, drive_right, drive_left, hold_time, chosen_action,
		halted_flag, last_of_run, input ready);
	modport sink (input valid, drive_right, drive_left, hold_time, chosen_action,
		halted_flag, last_of_run, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lfdc_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface lfdc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [lfdc_pkg::CFG_IDX_W-1:0]  index;
	logic [lfdc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/line_follower_drive_control_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line follower drive control unit
// Turns three reflectance samples and an echo time into servo drive requests.
// ----------------------------------------------------------------------------
// Usage:
//   sensor : one request per control step (samples right/center/left, echo).
//   drive  : one or two results per request; last_of_run marks the final one.
//            A first obstacle gives an avoid spin and then a forward drive.
//   cfg    : register writes (index, data), always ready; write only while idle.
// Path: an accepted request is held in the input register, then pushed into
//   the result queue, from which its results are offered on drive.
// Throughput: one request per cycle while each gives a single result and the
//   drive receiver keeps ready high; a request with two results holds the
//   drive channel for two transfers. The rate is set by the one-entry input
//   register feeding a four-entry result queue.
// Stall: while the receiver holds ready low, the queue fills; once full the
//   input register holds its request and sensor.ready drops.
// Reset: registers return to their defaults, run state clears, queue empties.
// ----------------------------------------------------------------------------
module line_follower_drive_control_unit #(
	parameter int SAMPLE_BITS = lfdc_pkg::SAMPLE_BITS
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lfdc_in_if.sink     sensor,
	lfdc_out_if.source  drive,
	lfdc_cfg_if.sink    cfg
);

	lfdc_pkg::cfg_t   regs;
	lfdc_pkg::entry_t push_entry;
	logic             push;
	logic             queue_full;

	lfdc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	lfdc_step #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.sensor     (sensor),
		.regs       (regs),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	lfdc_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.drive      (drive)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/lfdc_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// Holds thresholds and pulse settings; one register written per request.
// ----------------------------------------------------------------------------
module lfdc_cfg_regs (
	input  wire logic       clk,
	input  wire logic       arst_n,
	lfdc_cfg_if.sink        cfg,
	output lfdc_pkg::cfg_t  regs
);

	lfdc_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.line_threshold      <= lfdc_pkg::RST_LINE_THRESHOLD;
			regs_q.obstacle_echo_limit <= lfdc_pkg::RST_ECHO_LIMIT;
			regs_q.boost_after         <= lfdc_pkg::RST_BOOST_AFTER;
			regs_q.pulse_normal        <= lfdc_pkg::RST_PULSE_NORMAL;
			regs_q.pulse_boost         <= lfdc_pkg::RST_PULSE_BOOST;
			regs_q.pulse_inner         <= lfdc_pkg::RST_PULSE_INNER;
			regs_q.pulse_reverse       <= lfdc_pkg::RST_PULSE_REVERSE;
		end else if (cfg.valid) begin
			case (cfg.index)
				lfdc_pkg::REG_LINE_THRESHOLD: begin
					regs_q.line_threshold <= cfg.data[lfdc_pkg::THR_W-1:0];
				end
				lfdc_pkg::REG_ECHO_LIMIT: begin
					regs_q.obstacle_echo_limit <= cfg.data[lfdc_pkg::ECHO_W-1:0];
				end
				lfdc_pkg::REG_BOOST_AFTER: begin
					regs_q.boost_after <= cfg.data[lfdc_pkg::BOOST_W-1:0];
				end
				lfdc_pkg::REG_PULSE_NORMAL: begin
					regs_q.pulse_normal <= cfg.data[lfdc_pkg::PULSE_W-1:0];
				end
				lfdc_pkg::REG_PULSE_BOOST: begin
					regs_q.pulse_boost <= cfg.data[lfdc_pkg::PULSE_W-1:0];
				end
				lfdc_pkg::REG_PULSE_INNER: begin
					regs_q.pulse_inner <= cfg.data[lfdc_pkg::PULSE_W-1:0];
				end
				lfdc_pkg::REG_PULSE_REVERSE: begin
					regs_q.pulse_reverse <= cfg.data[lfdc_pkg::PULSE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/lfdc_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Control step
// Input register, action decision, run state and result pair for one request.
// ----------------------------------------------------------------------------
module lfdc_step #(
	parameter int SAMPLE_BITS = lfdc_pkg::SAMPLE_BITS
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	lfdc_in_if.sink             sensor,
	input  wire lfdc_pkg::cfg_t regs,
	input  wire logic           queue_full,
	output logic                push,
	output lfdc_pkg::entry_t    push_entry
);

	localparam int CMP_W = (SAMPLE_BITS > lfdc_pkg::THR_W) ? SAMPLE_BITS : lfdc_pkg::THR_W;

	logic                         valid_s1;
	logic [SAMPLE_BITS-1:0]       sr_s1;
	logic [SAMPLE_BITS-1:0]       sc_s1;
	logic [SAMPLE_BITS-1:0]       sl_s1;
	logic [lfdc_pkg::ECHO_W-1:0]  echo_s1;

	logic [1:0]                   hits_q;
	logic [lfdc_pkg::BOOST_W-1:0] run_q;
	logic [lfdc_pkg::ACT_W-1:0]   prev_q;
	logic [1:0]                   rep_q;

	logic [1:0]                   hits_d;
	logic [lfdc_pkg::BOOST_W-1:0] run_d;
	logic [lfdc_pkg::ACT_W-1:0]   prev_d;
	logic [1:0]                   rep_d;

	logic                         advance;
	logic                         halted;
	logic                         obstacle;
	logic                         on_r, on_c, on_l;
	logic [lfdc_pkg::ACT_W-1:0]   act;
	logic [lfdc_pkg::PULSE_W:0]   inner_sum;
	logic [lfdc_pkg::PULSE_W-1:0] inner;
	logic [lfdc_pkg::PULSE_W-1:0] fwd;
	logic [lfdc_pkg::PULSE_W-1:0] r_raw;
	logic [lfdc_pkg::PULSE_W-1:0] l_out;
	lfdc_pkg::res_t               stop_res;

	assign advance      = valid_s1 && !queue_full;
	assign sensor.ready = !valid_s1 || advance;
	assign push         = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sensor.ready) begin
			valid_s1 <= sensor.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sensor.ready && sensor.valid) begin
			sr_s1   <= sensor.sample_right;
			sc_s1   <= sensor.sample_center;
			sl_s1   <= sensor.sample_left;
			echo_s1 <= sensor.echo_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= 2'd0;
			run_q  <= '0;
			prev_q <= lfdc_pkg::ACT_FWD;
			rep_q  <= 2'd0;
		end else if (advance) begin
			hits_q <= hits_d;
			run_q  <= run_d;
			prev_q <= prev_d;
			rep_q  <= rep_d;
		end
	end

	assign halted   = hits_q[1];
	assign obstacle = (echo_s1 != '0) && (echo_s1 <= regs.obstacle_echo_limit);

	assign on_r = CMP_W'(sr_s1) <= CMP_W'(regs.line_threshold);
	assign on_c = CMP_W'(sc_s1) <= CMP_W'(regs.line_threshold);
	assign on_l = CMP_W'(sl_s1) <= CMP_W'(regs.line_threshold);

	always_comb begin
		if (on_r && !on_l) begin
			act = on_c ? lfdc_pkg::ACT_CURVE_R : lfdc_pkg::ACT_SPIN_R;
		end else if (on_l && !on_r) begin
			act = on_c ? lfdc_pkg::ACT_CURVE_L : lfdc_pkg::ACT_SPIN_L;
		end else begin
			act = lfdc_pkg::ACT_FWD;
		end
	end

	assign inner_sum = {1'b0, regs.pulse_normal} + {1'b0, regs.pulse_inner};

	always_comb begin
		stop_res.drive_right   = lfdc_pkg::PULSE_MID;
		stop_res.drive_left    = lfdc_pkg::PULSE_MID;
		stop_res.hold_time     = lfdc_pkg::HOLD_FOREVER;
		stop_res.chosen_action = lfdc_pkg::ACT_STOP;
		stop_res.halted_flag   = 1'b1;
		stop_res.last_of_run   = 1'b1;

		hits_d = hits_q;
		run_d  = run_q;
		prev_d = prev_q;
		rep_d  = rep_q;
		inner  = inner_sum[lfdc_pkg::PULSE_W:1];
		fwd    = regs.pulse_normal;
		r_raw  = regs.pulse_normal;
		l_out  = lfdc_pkg::mirror(regs.pulse_normal);

		push_entry.res0 = stop_res;
		push_entry.res1 = stop_res;
		push_entry.two  = 1'b0;

		if (halted) begin
			// stay stopped, state frozen
		end else if (obstacle) begin
			hits_d = hits_q + 2'd1;
			run_d  = '0;
			prev_d = lfdc_pkg::ACT_FWD;
			rep_d  = 2'd0;
			// straight run is already cleared here
			fwd = (regs.boost_after == '0) ? regs.pulse_boost : regs.pulse_normal;
			if (hits_q == 2'd0) begin
				push_entry.two = 1'b1;
				push_entry.res0.drive_right   = lfdc_pkg::clamp_pulse({1'b0, regs.pulse_reverse});
				push_entry.res0.drive_left    = lfdc_pkg::mirror(regs.pulse_normal);
				push_entry.res0.hold_time     = lfdc_pkg::HOLD_AVOID;
				push_entry.res0.chosen_action = lfdc_pkg::ACT_AVOID;
				push_entry.res0.halted_flag   = 1'b0;
				push_entry.res0.last_of_run   = 1'b0;
				push_entry.res1.drive_right   = lfdc_pkg::clamp_pulse({1'b0, fwd});
				push_entry.res1.drive_left    = lfdc_pkg::mirror(fwd);
				push_entry.res1.hold_time     = lfdc_pkg::HOLD_RESUME;
				push_entry.res1.chosen_action = lfdc_pkg::ACT_FWD;
				push_entry.res1.halted_flag   = 1'b0;
				push_entry.res1.last_of_run   = 1'b1;
			end
		end else begin
			if (act == lfdc_pkg::ACT_FWD) begin
				if (({1'b0, run_q} < ({1'b0, regs.boost_after} + 5'd1)) && (run_q != '1)) begin
					run_d = run_q + 4'd1;
				end
			end else begin
				run_d = '0;
			end
			if (act == prev_q) begin
				if (rep_q < 2'd2) begin
					rep_d = rep_q + 2'd1;
				end
			end else begin
				rep_d = 2'd0;
			end
			prev_d = act;
			if (rep_d >= 2'd2) begin
				inner = regs.pulse_inner;
			end
			fwd = (run_d >= regs.boost_after) ? regs.pulse_boost : regs.pulse_normal;
			case (act)
				lfdc_pkg::ACT_CURVE_R: begin
					r_raw = inner;
					l_out = lfdc_pkg::mirror(regs.pulse_normal);
				end
				lfdc_pkg::ACT_CURVE_L: begin
					r_raw = regs.pulse_normal;
					l_out = lfdc_pkg::mirror(inner);
				end
				lfdc_pkg::ACT_SPIN_R: begin
					r_raw = regs.pulse_reverse;
					l_out = lfdc_pkg::mirror(regs.pulse_normal);
				end
				lfdc_pkg::ACT_SPIN_L: begin
					r_raw = regs.pulse_normal;
					l_out = lfdc_pkg::mirror(regs.pulse_reverse);
				end
				default: begin
					r_raw = fwd;
					l_out = lfdc_pkg::mirror(fwd);
				end
			endcase
			push_entry.res0.drive_right   = lfdc_pkg::clamp_pulse({1'b0, r_raw});
			push_entry.res0.drive_left    = l_out;
			push_entry.res0.hold_time     = lfdc_pkg::HOLD_LINE;
			push_entry.res0.chosen_action = act;
			push_entry.res0.halted_flag   = 1'b0;
			push_entry.res0.last_of_run   = 1'b1;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/lfdc_out_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result queue
// Small queue of result pairs; drains one result per accepted transfer.
// ----------------------------------------------------------------------------
module lfdc_out_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire lfdc_pkg::entry_t push_entry,
	output logic                  full,
	lfdc_out_if.source            drive
);

	lfdc_pkg::entry_t                mem_q [lfdc_pkg::QUEUE_DEPTH];
	logic [lfdc_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [lfdc_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [lfdc_pkg::QCNT_W-1:0]     count_q;
	logic                            sub_q;
	lfdc_pkg::entry_t                head;
	lfdc_pkg::res_t                  cur;
	logic                            take;
	logic                            pop;

	assign full = (count_q == lfdc_pkg::QCNT_W'(lfdc_pkg::QUEUE_DEPTH));
	assign head = mem_q[rd_ptr_q];
	assign cur  = sub_q ? head.res1 : head.res0;

	assign drive.valid         = (count_q != '0);
	assign drive.drive_right   = cur.drive_right;
	assign drive.drive_left    = cur.drive_left;
	assign drive.hold_time     = cur.hold_time;
	assign drive.chosen_action = cur.chosen_action;
	assign drive.halted_flag   = cur.halted_flag;
	assign drive.last_of_run   = cur.last_of_run;

	assign take = drive.valid && drive.ready;
	// drop the entry once its last result is taken
	assign pop  = take && (sub_q || !head.two);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			sub_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + lfdc_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + lfdc_pkg::QPTR_W'(1);
				sub_q    <= 1'b0;
			end else if (take) begin
				sub_q <= 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + lfdc_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - lfdc_pkg::QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire
